// ----- src/w5ud_pkg.sv -----
// ============================================================================
// w5ud_pkg
// Shared widths, codes, types and helpers of the WENO5 derivative unit.
// ============================================================================
package w5ud_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;   // default fraction bits
  localparam int unsigned QW            = 32;   // sample / difference width
  localparam int unsigned DW            = QW + 1; // raw difference width
  localparam int unsigned NW            = 38;   // candidate stencil sums
  localparam int unsigned AW            = 36;   // indicator arguments
  localparam int unsigned EW            = 64;   // indicator width
  localparam int unsigned EPS12_W       = 36;   // 12 * eps_floor
  localparam int unsigned NORM_BITS     = 20;   // normalized indicator bits
  localparam int unsigned R2W           = 2 * NORM_BITS;
  localparam int unsigned SHW           = 6;    // normalizing shift amount
  localparam int unsigned LIN_W         = 3;    // linear weight width
  localparam int unsigned ALPHA_SHIFT   = 58;
  localparam int unsigned AL_W          = LIN_W + ALPHA_SHIFT; // alpha width
  localparam int unsigned SUM_W         = AL_W + 2;
  localparam int unsigned WEIGHT_BITS   = 24;
  localparam int unsigned DEN_W         = 27;   // 6 * weight sum
  localparam int unsigned PW            = 64;   // blended numerator
  localparam int unsigned QUO_W         = 33;   // quotient bits below clip
  localparam int unsigned INV_W         = 31;
  localparam int unsigned CFG_DW        = 32;
  localparam int unsigned CFG_AW        = 3;

  // pipeline depths of the fixed sections
  localparam int unsigned DIFF_LAT   = 3;
  localparam int unsigned SMOOTH_LAT = 8;
  localparam int unsigned BLEND_LAT  = 6;

  // linear weights 1, 6, 3 (lane 0 first)
  localparam logic [2:0][LIN_W-1:0] LIN_C = {3'd3, 3'd6, 3'd1};

  // register codes (word address bit 2)
  localparam logic REG_INV_SPACING = 1'b0;
  localparam logic REG_EPS_FLOOR   = 1'b1;

  localparam logic [INV_W-1:0]  INV_SPACING_RST = 31'd65536;
  localparam logic [CFG_DW-1:0] EPS_FLOOR_RST   = 32'd4295;

  typedef struct packed {
    logic                zero;
    logic                sat;
    logic [4:0][QW-1:0]  q;
  } qset_t;

  typedef struct packed {
    logic          zero;
    logic          sat;
    logic [NW-1:0] n1;
    logic [NW-1:0] n2;
    logic [NW-1:0] n3;
  } blend_tag_t;

  typedef struct packed {
    logic zero;
    logic sat;
    logic neg;
    logic ovf;
  } round_tag_t;

  // number of significant bits
  function automatic logic [6:0] bit_len64(input logic [63:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        n = 7'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ----- src/w5ud_diff.sv -----
// ============================================================================
// w5ud_diff
// Upwind selection, spacing scale and clamp of the five differences.
// ============================================================================
module w5ud_diff import w5ud_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [QW-1:0]    sample_m3_i,
  input  logic [QW-1:0]    sample_m2_i,
  input  logic [QW-1:0]    sample_m1_i,
  input  logic [QW-1:0]    sample_center_i,
  input  logic [QW-1:0]    sample_p1_i,
  input  logic [QW-1:0]    sample_p2_i,
  input  logic [QW-1:0]    sample_p3_i,
  input  logic [QW-1:0]    velocity_i,
  input  logic [INV_W-1:0] inv_spacing_i,
  output logic             valid_o,
  output qset_t            qset_o
);

  logic signed [QW-1:0] hi [5];
  logic signed [QW-1:0] lo [5];
  logic signed [DW-1:0] d_d [5];
  logic signed [DW-1:0] d_q [5];
  logic signed [PW:0]   p_d [5];
  logic signed [PW-1:0] p_q [5];
  logic [2:0]           vld_q;
  logic                 zero_d, zero1_q, zero2_q;
  qset_t                qset_d, qset_q;

  // stage 1: upwind pick
  always_comb begin
    zero_d = (velocity_i == '0);
    if (!velocity_i[QW-1]) begin
      hi = '{sample_m2_i, sample_m1_i, sample_center_i, sample_p1_i, sample_p2_i};
      lo = '{sample_m3_i, sample_m2_i, sample_m1_i, sample_center_i, sample_p1_i};
    end else begin
      hi = '{sample_p3_i, sample_p2_i, sample_p1_i, sample_center_i, sample_m1_i};
      lo = '{sample_p2_i, sample_p1_i, sample_center_i, sample_m1_i, sample_m2_i};
    end
    for (int i = 0; i < 5; i++) begin
      d_d[i] = zero_d ? '0 : (DW'(hi[i]) - DW'(lo[i]));
    end
  end

  // stage 2: scale
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      p_d[i] = d_q[i] * $signed({1'b0, inv_spacing_i});
    end
  end

  // stage 3: floor shift and clamp
  always_comb begin
    logic signed [PW-1:0] sh;
    qset_d.zero = zero2_q;
    qset_d.sat  = 1'b0;
    qset_d.q    = '0;
    for (int i = 0; i < 5; i++) begin
      sh = p_q[i] >>> FRAC_BITS;
      if (sh[PW-1:QW-1] != {(PW-QW+1){sh[PW-1]}}) begin
        qset_d.sat  = 1'b1;
        qset_d.q[i] = sh[PW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
        qset_d.q[i] = sh[QW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    zero1_q <= zero_d;
    for (int i = 0; i < 5; i++) begin
      p_q[i] <= p_d[i][PW-1:0];
    end
    zero2_q <= zero1_q;
    qset_q  <= qset_d;
  end

  assign valid_o = vld_q[2];
  assign qset_o  = qset_q;

endmodule

// ----- src/w5ud_smooth.sv -----
// ============================================================================
// w5ud_smooth
// Smoothness indicators, epsilon floor and normalization to 20 bits.
// ============================================================================
module w5ud_smooth import w5ud_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  qset_t                 qset_i,
  input  logic [EPS12_W-1:0]    eps12_i,
  output logic                  valid_o,
  output logic [2:0][R2W-1:0]   r2_o,
  output blend_tag_t            tag_o
);

  logic signed [NW-1:0] q [5];
  logic signed [NW-1:0] a_w [3];
  logic signed [NW-1:0] b_w [3];
  blend_tag_t           tag_d;

  logic [SMOOTH_LAT-1:0] vld_q;
  blend_tag_t            tag_q [SMOOTH_LAT];

  logic signed [AW-1:0] a_q [3];
  logic signed [AW-1:0] b_q [3];
  logic [EW-1:0] sqa_d [3], sqb_d [3], sqa_q [3], sqb_q [3];
  logic [EW-1:0] sa_d [3], sb_d [3], sa_q [3], sb_q [3];
  logic [EW-1:0] e_d [3], e_q [3], eh_q [3], ei_q [3];
  logic [EW-1:0] maxe_d, maxe_q;
  logic [SHW-1:0] s_d, s_q;
  logic [NORM_BITS-1:0] r_d [3], r_q [3];
  logic [R2W-1:0] r2_q [3];

  for (genvar k = 0; k < 5; k++) begin : g_q
    assign q[k] = NW'($signed(qset_i.q[k]));
  end

  // stage D: indicator arguments and candidate sums
  always_comb begin
    a_w[0] = q[0] - (q[1] <<< 1) + q[2];
    b_w[0] = q[0] - (q[1] <<< 2) + (q[2] <<< 1) + q[2];
    a_w[1] = q[1] - (q[2] <<< 1) + q[3];
    b_w[1] = q[1] - q[3];
    a_w[2] = q[2] - (q[3] <<< 1) + q[4];
    b_w[2] = (q[2] <<< 1) + q[2] - (q[3] <<< 2) + q[4];
    tag_d.zero = qset_i.zero;
    tag_d.sat  = qset_i.sat;
    tag_d.n1   = (q[0] <<< 1) - ((q[1] <<< 3) - q[1])
               + (q[2] <<< 3) + (q[2] <<< 1) + q[2];
    tag_d.n2   = (q[2] <<< 2) + q[2] - q[1] + (q[3] <<< 1);
    tag_d.n3   = (q[2] <<< 1) + (q[3] <<< 2) + q[3] - q[4];
  end

  // stage E: saturating squares
  always_comb begin
    logic [AW-1:0] ma, mb;
    for (int k = 0; k < 3; k++) begin
      ma = a_q[k][AW-1] ? AW'(-a_q[k]) : AW'(a_q[k]);
      mb = b_q[k][AW-1] ? AW'(-b_q[k]) : AW'(b_q[k]);
      sqa_d[k] = (|ma[AW-1:QW]) ? '1 : ma[QW-1:0] * ma[QW-1:0];
      sqb_d[k] = (|mb[AW-1:QW]) ? '1 : mb[QW-1:0] * mb[QW-1:0];
    end
  end

  // stage F: times 13 and times 3, saturating
  always_comb begin
    logic [EW+3:0] t13;
    logic [EW+1:0] t3;
    for (int k = 0; k < 3; k++) begin
      t13 = ({4'b0, sqa_q[k]} << 3) + ({4'b0, sqa_q[k]} << 2) + {4'b0, sqa_q[k]};
      t3  = ({2'b0, sqb_q[k]} << 1) + {2'b0, sqb_q[k]};
      sa_d[k] = (|t13[EW+3:EW]) ? '1 : t13[EW-1:0];
      sb_d[k] = (|t3[EW+1:EW]) ? '1 : t3[EW-1:0];
    end
  end

  // stage G: sum with epsilon, saturating
  always_comb begin
    logic [EW+1:0] tot;
    for (int k = 0; k < 3; k++) begin
      tot = {2'b0, sa_q[k]} + {2'b0, sb_q[k]} + (EW+2)'(eps12_i);
      e_d[k] = (|tot[EW+1:EW]) ? '1 : tot[EW-1:0];
    end
  end

  // stage H: largest indicator
  always_comb begin
    logic [EW-1:0] m01;
    m01    = (e_q[0] > e_q[1]) ? e_q[0] : e_q[1];
    maxe_d = (m01 > e_q[2]) ? m01 : e_q[2];
  end

  // stage I: normalizing shift
  always_comb begin
    logic [6:0] bl;
    bl  = bit_len64(maxe_q);
    s_d = (bl > 7'(NORM_BITS)) ? SHW'(bl - 7'(NORM_BITS)) : '0;
  end

  // stage J: shifted indicators, zero read as one
  always_comb begin
    logic [EW-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      sh = ei_q[k] >> s_q;
      r_d[k] = (sh[NORM_BITS-1:0] == '0) ? NORM_BITS'(1) : sh[NORM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SMOOTH_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_d;
    for (int i = 1; i < SMOOTH_LAT; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
    for (int k = 0; k < 3; k++) begin
      a_q[k]   <= AW'(a_w[k]);
      b_q[k]   <= AW'(b_w[k]);
      sqa_q[k] <= sqa_d[k];
      sqb_q[k] <= sqb_d[k];
      sa_q[k]  <= sa_d[k];
      sb_q[k]  <= sb_d[k];
      e_q[k]   <= e_d[k];
      eh_q[k]  <= e_q[k];
      ei_q[k]  <= eh_q[k];
      r_q[k]   <= r_d[k];
      r2_q[k]  <= r_q[k] * r_q[k];
    end
    maxe_q <= maxe_d;
    s_q    <= s_d;
  end

  assign valid_o = vld_q[SMOOTH_LAT-1];
  assign tag_o   = tag_q[SMOOTH_LAT-1];
  for (genvar k = 0; k < 3; k++) begin : g_out
    assign r2_o[k] = r2_q[k];
  end

endmodule

// ----- src/w5ud_div.sv -----
// ============================================================================
// w5ud_div
// Pipelined restoring divider, one quotient bit per stage, shared tag.
// ============================================================================
module w5ud_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NUM_W = 8,
  parameter int unsigned DEN_W = 8,
  parameter int unsigned TAG_W = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]     num_i,
  input  logic [LANES-1:0][DEN_W-1:0]     rem_i,   // must be below den_i
  input  logic [LANES-1:0][DEN_W-1:0]     den_i,
  input  logic [TAG_W-1:0]                tag_i,
  output logic                            valid_o,
  output logic [LANES-1:0][NUM_W-1:0]     quo_o,
  output logic [LANES-1:0][DEN_W-1:0]     rem_o,
  output logic [LANES-1:0][DEN_W-1:0]     den_o,
  output logic [TAG_W-1:0]                tag_o
);

  logic [NUM_W-1:0]                         vld_q;
  logic [NUM_W-1:0][LANES-1:0][DEN_W-1:0]   rem_q;
  logic [NUM_W-1:0][LANES-1:0][DEN_W-1:0]   den_q;
  logic [NUM_W-1:0][LANES-1:0][NUM_W-1:0]   nq_q;   // dividend bits in, quotient out
  logic [NUM_W-1:0][TAG_W-1:0]              tag_q;

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic                          vld_in;
    logic [LANES-1:0][DEN_W-1:0]   rem_in, den_in, rem_d;
    logic [LANES-1:0][NUM_W-1:0]   nq_in, nq_d;
    logic [TAG_W-1:0]              tag_in;

    if (g == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign nq_in  = num_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[g-1];
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign nq_in  = nq_q[g-1];
      assign tag_in = tag_q[g-1];
    end

    always_comb begin
      logic [DEN_W:0] rem2, sub;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        rem2     = {rem_in[l], nq_in[l][NUM_W-1]};
        sub      = rem2 - {1'b0, den_in[l]};
        ge       = (rem2 >= {1'b0, den_in[l]});
        rem_d[l] = ge ? sub[DEN_W-1:0] : rem2[DEN_W-1:0];
        nq_d[l]  = {nq_in[l][NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= rem_d;
      den_q[g] <= den_in;
      nq_q[g]  <= nq_d;
      tag_q[g] <= tag_in;
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = nq_q[NUM_W-1];
  assign rem_o   = rem_q[NUM_W-1];
  assign den_o   = den_q[NUM_W-1];
  assign tag_o   = tag_q[NUM_W-1];

endmodule

// ----- src/w5ud_blend.sv -----
// ============================================================================
// w5ud_blend
// Weight scaling, weighted candidate sum and setup of the final divide.
// ============================================================================
module w5ud_blend import w5ud_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [2:0][AL_W-1:0]  alpha_i,
  input  blend_tag_t            tag_i,
  output logic                  valid_o,
  output logic [QUO_W-1:0]      mag_lo_o,
  output logic [DEN_W-1:0]      rem_o,
  output logic [DEN_W-1:0]      den_o,
  output round_tag_t            tag_o
);

  logic [BLEND_LAT-1:0] vld_q;
  blend_tag_t           tag_q [BLEND_LAT-1];

  logic [AL_W-1:0]        al1_q [3], al2_q [3];
  logic [SUM_W-1:0]       sum_q;
  logic [SHW-1:0]         t_d, t_q;
  logic [WEIGHT_BITS-1:0] w_d [3], w_q [3];
  logic [WEIGHT_BITS-1:0] wsum_d, wsum_q;
  logic signed [PW-1:0]   prod_d [3], prod_q [3];
  logic [DEN_W-1:0]       den_d, den4_q, den5_q, den6_q;
  logic signed [PW-1:0]   num_q;
  logic [PW-1:0]          mag;
  round_tag_t             rtag_d, rtag_q;
  logic [QUO_W-1:0]       lo_q;
  logic [DEN_W-1:0]       rem_q;

  // weight shift
  always_comb begin
    logic [6:0] bl;
    bl  = bit_len64(64'(sum_q));
    t_d = (bl > 7'(WEIGHT_BITS)) ? SHW'(bl - 7'(WEIGHT_BITS)) : '0;
  end

  always_comb begin
    logic [AL_W-1:0] sh;
    wsum_d = '0;
    for (int k = 0; k < 3; k++) begin
      sh     = al2_q[k] >> t_q;
      w_d[k] = sh[WEIGHT_BITS-1:0];
      wsum_d = wsum_d + w_d[k];
    end
  end

  // products and 6 * weight sum
  always_comb begin
    prod_d[0] = $signed({1'b0, w_q[0]}) * $signed(tag_q[2].n1);
    prod_d[1] = $signed({1'b0, w_q[1]}) * $signed(tag_q[2].n2);
    prod_d[2] = $signed({1'b0, w_q[2]}) * $signed(tag_q[2].n3);
    den_d     = DEN_W'({wsum_q, 2'b0}) + DEN_W'({wsum_q, 1'b0});
    if (den_d == '0) begin
      den_d = DEN_W'(1);
    end
  end

  // sign, magnitude and clip precheck
  always_comb begin
    rtag_d.zero = tag_q[4].zero;
    rtag_d.sat  = tag_q[4].sat;
    rtag_d.neg  = num_q[PW-1];
    mag         = rtag_d.neg ? PW'(-num_q) : PW'(num_q);
    rtag_d.ovf  = (mag[PW-1:QUO_W] >= (PW-QUO_W)'(den5_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[BLEND_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    for (int i = 1; i < BLEND_LAT - 1; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
    sum_q <= SUM_W'(alpha_i[0]) + SUM_W'(alpha_i[1]) + SUM_W'(alpha_i[2]);
    for (int k = 0; k < 3; k++) begin
      al1_q[k]  <= alpha_i[k];
      al2_q[k]  <= al1_q[k];
      w_q[k]    <= w_d[k];
      prod_q[k] <= prod_d[k];
    end
    t_q    <= t_d;
    wsum_q <= wsum_d;
    den4_q <= den_d;
    num_q  <= prod_q[0] + prod_q[1] + prod_q[2];
    den5_q <= den4_q;
    den6_q <= den5_q;
    rtag_q <= rtag_d;
    lo_q   <= mag[QUO_W-1:0];
    rem_q  <= rtag_d.ovf ? '0 : mag[QUO_W+DEN_W-1:QUO_W];
  end

  assign valid_o  = vld_q[BLEND_LAT-1];
  assign mag_lo_o = lo_q;
  assign rem_o    = rem_q;
  assign den_o    = den6_q;
  assign tag_o    = rtag_q;

endmodule

// ----- src/weno5_upwind_derivative_unit.sv -----
// ============================================================================
// weno5_upwind_derivative_unit
// Fifth-order WENO upwind derivative of one stencil, Q16.16, saturating.
// ============================================================================
//
// Channel   Direction  Signals                                  Transfer
// --------  ---------  ---------------------------------------  ----------------------
// stencil   in         start, busy, sample_*_i, velocity_i      start high, busy low
// result    out        result_valid_o, derivative_o, saturated_o one-cycle strobe
// config    in/out     psel, penable, pwrite, paddr, pwdata,     access phase, pready
//                      prdata, pready
//
// One stencil may be started every cycle; busy is always low. Results leave
// in the order of their starts. The two pipelined restoring dividers
// (61-bit weight divide, 33-bit blend divide) make up most of the pipeline.
// Reset clears the valid bits of every stage and loads the register
// defaults; no clearing pass. The receiver cannot stall, so nothing in the
// pipe ever waits.
//
// Registers: 0x0 inv_spacing (31 bits, unsigned Q15.16), 0x4 eps_floor.
// ============================================================================
module weno5_upwind_derivative_unit import w5ud_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // stencil channel
  input  logic              start,
  output logic              busy,
  input  logic [QW-1:0]     sample_m3_i,
  input  logic [QW-1:0]     sample_m2_i,
  input  logic [QW-1:0]     sample_m1_i,
  input  logic [QW-1:0]     sample_center_i,
  input  logic [QW-1:0]     sample_p1_i,
  input  logic [QW-1:0]     sample_p2_i,
  input  logic [QW-1:0]     sample_p3_i,
  input  logic [QW-1:0]     velocity_i,
  // result channel
  output logic              result_valid_o,
  output logic [QW-1:0]     derivative_o,
  output logic              saturated_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned LATENCY =
      DIFF_LAT + SMOOTH_LAT + AL_W + BLEND_LAT + QUO_W + 1;
  localparam logic [QUO_W:0] POS_MAX = (QUO_W+1)'(32'h7FFF_FFFF);
  localparam logic [QUO_W:0] NEG_MAX = (QUO_W+1)'(32'h8000_0000);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [INV_W-1:0]   inv_spacing_q;
  logic [CFG_DW-1:0]  eps_floor_q;
  logic [EPS12_W-1:0] eps12;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_spacing_q <= INV_SPACING_RST;
      eps_floor_q   <= EPS_FLOOR_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_INV_SPACING: inv_spacing_q <= pwdata[INV_W-1:0];
        REG_EPS_FLOOR:   eps_floor_q   <= pwdata;
        default:         ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == '0) begin
      unique case (paddr[2])
        REG_INV_SPACING: prdata = CFG_DW'(inv_spacing_q);
        REG_EPS_FLOOR:   prdata = eps_floor_q;
        default:         prdata = '0;
      endcase
    end
  end

  // 12 * eps as 8x + 4x
  assign eps12 = EPS12_W'({eps_floor_q, 3'b0}) + EPS12_W'({eps_floor_q, 2'b0});

  // fully pipelined, never holds off a start
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Differences: upwind pick, scale by inv_spacing, clamp
  // --------------------------------------------------------------------------
  logic  diff_vld;
  qset_t qset;

  w5ud_diff #(
    .FRAC_BITS(FRAC_BITS)
  ) u_diff (
    .clk_i,
    .rst_ni,
    .valid_i         (start && !busy),
    .sample_m3_i,
    .sample_m2_i,
    .sample_m1_i,
    .sample_center_i,
    .sample_p1_i,
    .sample_p2_i,
    .sample_p3_i,
    .velocity_i,
    .inv_spacing_i   (inv_spacing_q),
    .valid_o         (diff_vld),
    .qset_o          (qset)
  );

  // --------------------------------------------------------------------------
  // Smoothness indicators, normalized and squared for the weight divide
  // --------------------------------------------------------------------------
  logic                 sm_vld;
  logic [2:0][R2W-1:0]  r2;
  blend_tag_t           sm_tag;

  w5ud_smooth u_smooth (
    .clk_i,
    .rst_ni,
    .valid_i (diff_vld),
    .qset_i  (qset),
    .eps12_i (eps12),
    .valid_o (sm_vld),
    .r2_o    (r2),
    .tag_o   (sm_tag)
  );

  // --------------------------------------------------------------------------
  // alpha_k = c_k * 2^58 / r_k^2, three lanes in lock step
  // --------------------------------------------------------------------------
  logic [2:0][AL_W-1:0]       al_num;
  logic [2:0][AL_W-1:0]       alpha;
  logic [2:0][R2W-1:0]        al_rem_unused, al_den_unused;
  logic [$bits(blend_tag_t)-1:0] al_tag_bits;
  logic                       al_vld;
  blend_tag_t                 al_tag;

  for (genvar k = 0; k < 3; k++) begin : g_alnum
    assign al_num[k] = {LIN_C[k], {ALPHA_SHIFT{1'b0}}};
  end

  w5ud_div #(
    .LANES (3),
    .NUM_W (AL_W),
    .DEN_W (R2W),
    .TAG_W ($bits(blend_tag_t))
  ) u_alpha_div (
    .clk_i,
    .rst_ni,
    .valid_i (sm_vld),
    .num_i   (al_num),
    .rem_i   ('0),
    .den_i   (r2),
    .tag_i   (sm_tag),
    .valid_o (al_vld),
    .quo_o   (alpha),
    .rem_o   (al_rem_unused),
    .den_o   (al_den_unused),
    .tag_o   (al_tag_bits)
  );

  assign al_tag = blend_tag_t'(al_tag_bits);

  // --------------------------------------------------------------------------
  // Weighted blend and divide setup
  // --------------------------------------------------------------------------
  logic             bl_vld;
  logic [QUO_W-1:0] bl_lo;
  logic [DEN_W-1:0] bl_rem, bl_den;
  round_tag_t       bl_tag;

  w5ud_blend u_blend (
    .clk_i,
    .rst_ni,
    .valid_i  (al_vld),
    .alpha_i  (alpha),
    .tag_i    (al_tag),
    .valid_o  (bl_vld),
    .mag_lo_o (bl_lo),
    .rem_o    (bl_rem),
    .den_o    (bl_den),
    .tag_o    (bl_tag)
  );

  // --------------------------------------------------------------------------
  // |num| / (6 * sum): upper bits preloaded as the remainder
  // --------------------------------------------------------------------------
  logic                          dv_vld;
  logic [0:0][QUO_W-1:0]         dv_quo;
  logic [0:0][DEN_W-1:0]         dv_rem, dv_den;
  logic [$bits(round_tag_t)-1:0] dv_tag_bits;
  round_tag_t                    dv_tag;

  w5ud_div #(
    .LANES (1),
    .NUM_W (QUO_W),
    .DEN_W (DEN_W),
    .TAG_W ($bits(round_tag_t))
  ) u_out_div (
    .clk_i,
    .rst_ni,
    .valid_i (bl_vld),
    .num_i   (bl_lo),
    .rem_i   (bl_rem),
    .den_i   (bl_den),
    .tag_i   (bl_tag),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .rem_o   (dv_rem),
    .den_o   (dv_den),
    .tag_o   (dv_tag_bits)
  );

  assign dv_tag = round_tag_t'(dv_tag_bits);

  // --------------------------------------------------------------------------
  // Round half away from zero, clip, apply sign; zero velocity gives zero
  // --------------------------------------------------------------------------
  logic            out_vld_q;
  logic [QW-1:0]   deriv_d, deriv_q;
  logic            sat_d, sat_q;

  always_comb begin
    logic           rnd, clip;
    logic [QUO_W:0] qv, magv;
    rnd  = ({dv_rem[0], 1'b0} >= {1'b0, dv_den[0]});
    qv   = {1'b0, dv_quo[0]} + (QUO_W+1)'(rnd);
    clip = dv_tag.ovf || (!dv_tag.neg && (qv > POS_MAX))
                      || (dv_tag.neg && (qv > NEG_MAX));
    magv = clip ? (dv_tag.neg ? NEG_MAX : POS_MAX) : qv;
    if (dv_tag.zero) begin
      deriv_d = '0;
      sat_d   = 1'b0;
    end else begin
      deriv_d = dv_tag.neg ? QW'(-magv[QW-1:0]) : magv[QW-1:0];
      sat_d   = dv_tag.sat || clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    deriv_q <= deriv_d;
    sat_q   <= sat_d;
  end

  assign result_valid_o = out_vld_q;
  assign derivative_o   = deriv_q;
  assign saturated_o    = sat_q;

`ifndef SYNTHESIS
  // every transfer in comes out after the fixed latency
  a_start_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("result missing after start");

  // no result without a start
  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without start");

  // zero velocity yields an unsaturated zero
  a_zero_velocity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && velocity_i == '0) |->
      ##LATENCY (derivative_o == '0 && !saturated_o))
    else $error("zero velocity gave nonzero result");
`endif

endmodule
